// ----- hdl/matrix_stack_mult4x4_core_macros.svh -----
// assertion macros for the matrix stack core
// expects clk and arst_n in the scope of each use
`ifndef MATRIX_STACK_MULT4X4_CORE_MACROS_SVH
`define MATRIX_STACK_MULT4X4_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSM4_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MSM4_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/msm4_pkg.sv -----
// shared types, operation codes and default sizes for the matrix stack core
// no dependencies
package msm4_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int WORD_W          = 32;
	localparam int DEPTH_W         = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [3:0][WORD_W-1:0]   row_t;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_RESET = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

endpackage

// ----- hdl/matrix_stack_mult4x4_core.sv -----
// matrix stack core: stack store, operand buffer, shared mac unit and row emitter
// depends on msm4_pkg and matrix_stack_mult4x4_core_macros.svh

// Stack of 4x4 signed fixed-point transform matrices holding one identity after
// reset. A push arrives as four operand-row requests; rows 0 to 2 are only
// buffered and do not stall the input. Row 3 starts the product previous_top *
// operand on one shared 32x32 multiply-accumulate unit, one product per cycle;
// a completed push takes the request, runs the macs, drains the mac pipeline
// and then emits the result rows one at a time through the single read port of
// the stack memory. Pop, reset to identity and a push onto a full stack only emit
// the four rows of the top, and the emitter waits while the output side stalls.
// Input stall is high from row 3 or a pop/reset until the last result row is in
// the output register. Level zero always reads as identity, so the stack memory
// needs no clearing pass after reset.
`include "matrix_stack_mult4x4_core_macros.svh"

module matrix_stack_mult4x4_core #(
	parameter int STACK_DEPTH = msm4_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = msm4_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [1:0]                    row_index,
	input  msm4_pkg::word_t               in_col0,
	input  msm4_pkg::word_t               in_col1,
	input  msm4_pkg::word_t               in_col2,
	input  msm4_pkg::word_t               in_col3,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    out_row,
	output msm4_pkg::word_t               out_col0,
	output msm4_pkg::word_t               out_col1,
	output msm4_pkg::word_t               out_col2,
	output msm4_pkg::word_t               out_col3,
	output logic [msm4_pkg::DEPTH_W-1:0]  depth,
	output logic                          overflow,
	output logic                          last
);
	import msm4_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH * 4);
	localparam logic [WORD_W-1:0] ONE = WORD_W'(64'd1 << FRAC_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [5:0]      cnt_q;
	logic [1:0]      row_q;
	logic            ovf_q;
	logic            v_s1, v_s2;
	logic [5:0]      idx_s1, idx_s2;
	word_t           b_s1;
	logic signed [63:0] prod_s2;
	word_t           acc_q;
	row_t            res_row_q;
	logic            out_valid_q;

	logic [1:0]      out_row_q;
	row_t            out_cols_q;
	logic [DEPTH_W-1:0] depth_q;
	logic            ovf_out_q;
	logic            last_q;

	row_t            mem_q [STACK_DEPTH*4];
	row_t            rd_data_q;
	logic            rd_lvl0_q;
	logic [1:0]      rd_row_q;
	row_t            opbuf_q [4];

	logic            in_acc;
	logic            out_free;
	logic            ld;
	logic [1:0]      rd_row;
	logic [CW-1:0]   rd_level;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;
	row_t            wr_row;
	row_t            ident_row;
	row_t            a_row;
	word_t           a_word;
	word_t           acc_base;
	logic signed [63:0] prod_sh;
	logic signed [65:0] sum;
	word_t           sat;
	logic [1:0]      k2, j2, i2;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign ld       = (state_q == S_EMIT_LD) && out_free;

	// read row: mac walks rows of the previous top, emitter walks rows of the top
	assign rd_row   = (state_q == S_MAC) ? cnt_q[5:4] : row_q;
	assign rd_level = count_q - CW'(1);
	assign rd_addr  = AW'({rd_level, rd_row});

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			ident_row[c] = (2'(c) == rd_row_q) ? ONE : '0;
		end
	end

	// level zero is never written, it always reads as identity
	assign a_row  = rd_lvl0_q ? ident_row : rd_data_q;
	assign a_word = a_row[idx_s1[1:0]];

	assign k2 = idx_s2[1:0];
	assign j2 = idx_s2[3:2];
	assign i2 = idx_s2[5:4];

	assign acc_base = (k2 == 2'd0) ? '0 : acc_q;
	assign prod_sh  = prod_s2 >>> FRAC_BITS;
	assign sum      = 66'(acc_base) + 66'(prod_sh);

	always_comb begin
		if (sum[65:31] == '0 || sum[65:31] == '1) begin
			sat = sum[31:0];
		end else if (sum[65]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7fff_ffff;
		end
	end

	assign wr_en   = v_s2 && (k2 == 2'd3) && (j2 == 2'd3);
	assign wr_addr = AW'({count_q, i2});

	always_comb begin
		wr_row    = res_row_q;
		wr_row[3] = sat;
	end

	// stack memory, one row per word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_lvl0_q <= (count_q == CW'(1));
		rd_row_q  <= rd_row;
	end

	// operand buffer and mac datapath
	always_ff @(posedge clk) begin
		if (in_acc && operation == OP_PUSH) begin
			opbuf_q[row_index] <= {in_col3, in_col2, in_col1, in_col0};
		end
		b_s1    <= opbuf_q[cnt_q[1:0]][cnt_q[3:2]];
		prod_s2 <= a_word * b_s1;
		if (v_s2) begin
			acc_q         <= sat;
			res_row_q[j2] <= sat;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ld) begin
			out_row_q  <= row_q;
			out_cols_q <= a_row;
			depth_q    <= DEPTH_W'(count_q);
			ovf_out_q  <= ovf_q;
			last_q     <= (row_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CW'(1);
			cnt_q       <= '0;
			row_q       <= '0;
			ovf_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			idx_s1      <= '0;
			idx_s2      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1   <= (state_q == S_MAC);
			idx_s1 <= cnt_q;
			v_s2   <= v_s1;
			idx_s2 <= idx_s1;

			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (operation)
							OP_PUSH: begin
								if (row_index == 2'd3) begin
									if (count_q >= CW'(STACK_DEPTH)) begin
										ovf_q   <= 1'b1;
										row_q   <= '0;
										state_q <= S_EMIT_RD;
									end else begin
										cnt_q   <= '0;
										state_q <= S_MAC;
									end
								end
							end
							OP_POP: begin
								if (count_q > CW'(1)) begin
									count_q <= count_q - CW'(1);
								end
								ovf_q   <= 1'b0;
								row_q   <= '0;
								state_q <= S_EMIT_RD;
							end
							OP_RESET: begin
								count_q <= CW'(1);
								ovf_q   <= 1'b0;
								row_q   <= '0;
								state_q <= S_EMIT_RD;
							end
							default: begin
							end
						endcase
					end
				end
				S_MAC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last row of the product is written this cycle
					if (v_s2 && idx_s2 == 6'd63) begin
						count_q <= count_q + CW'(1);
						ovf_q   <= 1'b0;
						row_q   <= '0;
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						if (row_q == 2'd3) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + 2'd1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col0  = out_cols_q[0];
	assign out_col1  = out_cols_q[1];
	assign out_col2  = out_cols_q[2];
	assign out_col3  = out_cols_q[3];
	assign depth     = depth_q;
	assign overflow  = ovf_out_q;
	assign last      = last_q;

	`MSM4_ASSERT_IMP(a_last_row, out_valid_q && last_q, out_row_q == 2'd3, "last flag off row three")
	`MSM4_ASSERT_IMP(a_wr_room, wr_en, count_q < CW'(STACK_DEPTH), "product written past full stack")
	`MSM4_ASSERT_NXT(a_push_start,
		in_acc && operation == OP_PUSH && row_index == 2'd3 && count_q < CW'(STACK_DEPTH),
		state_q == S_MAC, "completed push did not start the mac")
	`MSM4_ASSERT_NXT(a_pop_dec, in_acc && operation == OP_POP && count_q > CW'(1),
		count_q == $past(count_q) - CW'(1), "pop did not lower the depth")

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for matrix_stack_mult4x4_core: directed then random requests
// keeps its own copy of the matrix stack in a scoreboard class and checks every row
// depends on msm4_pkg and the core rtl only
module testbench;
	import msm4_pkg::*;

	localparam int LEVELS      = STACK_DEPTH_DEF;
	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN       = 200;
	localparam longint SAT_HI  = 2147483647;
	localparam longint SAT_LO  = -SAT_HI - 1;

	localparam word_t W_MAX  = 32'sh7fffffff;
	localparam word_t W_MIN  = 32'sh80000000;
	localparam word_t W_ONE  = 32'sd1 <<< FRAC;
	localparam word_t W_NEG1 = -32'sd1;
	localparam word_t W_ZERO = 32'sd0;

	typedef struct packed {
		logic [1:0]         row_num;
		row_t               cols;
		logic [DEPTH_W-1:0] depth;
		logic               overflow;
		logic               last;
	} top_row_t;

	class mat_stack_scoreboard;
		word_t    levels [LEVELS][16];
		word_t    operand [16];
		int       count;
		int       errors;
		top_row_t expected_rows [$];

		function new();
			errors = 0;
			load_identity();
		endfunction

		function void load_identity();
			count = 1;
			for (int i = 0; i < 16; i++)
				levels[0][i] = ((i / 4) == (i % 4)) ? W_ONE : W_ZERO;
		endfunction

		// four rows of the current top, as the core emits them
		function void queue_top(bit ovf);
			top_row_t t;
			for (int r = 0; r < 4; r++) begin
				t.row_num  = r[1:0];
				for (int c = 0; c < 4; c++)
					t.cols[c] = levels[count-1][r*4+c];
				t.depth    = count[DEPTH_W-1:0];
				t.overflow = ovf;
				t.last     = (r == 3);
				expected_rows.push_back(t);
			end
		endfunction

		function void note_request(op_t op, logic [1:0] row, row_t cols);
			longint acc;
			longint prod;
			case (op)
			OP_PUSH: begin
				for (int c = 0; c < 4; c++)
					operand[row*4+c] = cols[c];
				if (row == 2'd3) begin
					if (count >= LEVELS) begin
						queue_top(1'b1);
					end else begin
						// new top = old top * operand, floor per product, clamp per sum
						for (int i = 0; i < 4; i++) begin
							for (int j = 0; j < 4; j++) begin
								acc = 0;
								for (int k = 0; k < 4; k++) begin
									prod = longint'(levels[count-1][i*4+k]) *
										longint'(operand[k*4+j]);
									acc = acc + (prod >>> FRAC);
									if (acc > SAT_HI)
										acc = SAT_HI;
									else if (acc < SAT_LO)
										acc = SAT_LO;
								end
								levels[count][i*4+j] = acc[31:0];
							end
						end
						count++;
						queue_top(1'b0);
					end
				end
			end
			OP_POP: begin
				if (count > 1)
					count--;
				queue_top(1'b0);
			end
			OP_RESET: begin
				load_identity();
				queue_top(1'b0);
			end
			default: ;
			endcase
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_row(top_row_t got);
			top_row_t want;
			if (expected_rows.size() == 0) begin
				$error("result row %0d arrived with no request outstanding", got.row_num);
				errors++;
				return;
			end
			want = expected_rows.pop_front();
			compare("out_row", 32'(want.row_num), 32'(got.row_num));
			compare("out_col0", want.cols[0], got.cols[0]);
			compare("out_col1", want.cols[1], got.cols[1]);
			compare("out_col2", want.cols[2], got.cols[2]);
			compare("out_col3", want.cols[3], got.cols[3]);
			compare("depth", 32'(want.depth), 32'(got.depth));
			compare("overflow", 32'(want.overflow), 32'(got.overflow));
			compare("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [1:0]         row_index;
	word_t              in_col0, in_col1, in_col2, in_col3;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         out_row;
	word_t              out_col0, out_col1, out_col2, out_col3;
	logic [DEPTH_W-1:0] depth;
	logic               overflow;
	logic               last;

	logic                in_taken = 1'b0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  cycles;
	mat_stack_scoreboard sb = new;

	matrix_stack_mult4x4_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.row_index (row_index),
		.in_col0   (in_col0),
		.in_col1   (in_col1),
		.in_col2   (in_col2),
		.in_col3   (in_col3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.out_col0  (out_col0),
		.out_col1  (out_col1),
		.out_col2  (out_col2),
		.out_col3  (out_col3),
		.depth     (depth),
		.overflow  (overflow),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// both handshakes sampled at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(op_t'(operation), row_index,
					{in_col3, in_col2, in_col1, in_col0});
			if (out_valid && !out_stall)
				sb.check_row({out_row, {out_col3, out_col2, out_col1, out_col0},
					depth, overflow, last});
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic row_t make_row(word_t c0, word_t c1, word_t c2, word_t c3);
		return {c3, c2, c1, c0};
	endfunction

	// mostly values near one so deep stacks do not all clamp
	function automatic word_t rand_word();
		word_t v;
		case ($urandom_range(9))
		6: v = ($urandom_range(1) != 0) ? W_ONE : -W_ONE;
		7: v = ($urandom_range(1) != 0) ? W_MAX : W_MIN;
		8, 9: v = $urandom;
		default: v = word_t'($urandom_range(0, 262143)) - word_t'(131072);
		endcase
		return v;
	endfunction

	function automatic row_t rand_row();
		return make_row(rand_word(), rand_word(), rand_word(), rand_word());
	endfunction

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic send(op_t op, logic [1:0] row, row_t cols);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation <= op;
		row_index <= row;
		in_col0   <= cols[0];
		in_col1   <= cols[1];
		in_col2   <= cols[2];
		in_col3   <= cols[3];
		in_valid  <= 1'b1;
		@(negedge clk);
		while (!in_taken)
			@(negedge clk);
	endtask

	task automatic run_phase(int n_items);
		int sent;
		int pick;
		int n_part;
		int j;
		int tmp;
		int order [3];
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				// whole push, rows 0 to 2 in any order, row 3 closes it
				order = '{0, 1, 2};
				for (int i = 2; i > 0; i--) begin
					j = $urandom_range(i);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (int i = 0; i < 3; i++)
					send(OP_PUSH, order[i][1:0], rand_row());
				send(OP_PUSH, 2'd3, rand_row());
				sent += 4;
			end else if (pick < 62) begin
				// row 3 alone reuses whatever rows are buffered
				send(OP_PUSH, 2'd3, rand_row());
				sent++;
			end else if (pick < 75) begin
				send(OP_POP, 2'($urandom_range(3)), rand_row());
				sent++;
			end else if (pick < 81) begin
				send(OP_RESET, 2'($urandom_range(3)), rand_row());
				sent++;
			end else if (pick < 88) begin
				send(OP_NONE, 2'($urandom_range(3)), rand_row());
				sent++;
			end else begin
				// push left unfinished
				n_part = $urandom_range(1, 2);
				for (int i = 0; i < n_part; i++)
					send(OP_PUSH, 2'($urandom_range(2)), rand_row());
				sent += n_part;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_PUSH;
		row_index = 2'd0;
		in_col0   = W_ZERO;
		in_col1   = W_ZERO;
		in_col2   = W_ZERO;
		in_col3   = W_ZERO;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pop with a single matrix, ignored code, reset while already at identity
		send(OP_POP, 2'd0, make_row(W_ZERO, W_ZERO, W_ZERO, W_ZERO));
		send(OP_NONE, 2'd3, make_row(W_MAX, W_MIN, W_NEG1, W_ONE));
		send(OP_RESET, 2'd2, make_row(W_NEG1, W_NEG1, W_NEG1, W_NEG1));
		// identity times extremes gives the extremes back exactly
		send(OP_PUSH, 2'd0, make_row(W_MAX, W_MIN, W_ZERO, W_NEG1));
		send(OP_PUSH, 2'd1, make_row(W_MIN, W_MAX, W_ONE, W_ZERO));
		send(OP_PUSH, 2'd2, make_row(W_ZERO, W_NEG1, W_MAX, W_MIN));
		send(OP_PUSH, 2'd3, make_row(W_ONE, W_ZERO, W_MIN, W_MAX));
		// extremes times extremes clamps both ways
		send(OP_PUSH, 2'd3, make_row(W_MAX, W_MAX, W_MAX, W_MAX));
		// fill the stack, then push once more onto the full stack
		while (sb.count < LEVELS)
			send(OP_PUSH, 2'd3, rand_row());
		send(OP_PUSH, 2'd3, rand_row());
		send(OP_POP, 2'd1, rand_row());
		send(OP_RESET, 2'd0, rand_row());

		send_idle_pct = 31;
		recv_idle_pct = 50;
		run_phase(45);
		send_idle_pct = 50;
		recv_idle_pct = 31;
		run_phase(45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(45);
		in_valid <= 1'b0;

		while (sb.expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/msm4_pkg.sv
hdl/matrix_stack_mult4x4_core.sv
bench/testbench.sv
